FILE: rtl/opi_pkg.sv
// Shared types and constants for the odometry pose integrator.
// No dependencies; every other file of the block but opi_checker imports this package.
package opi_pkg;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int RATE_W  = 24;
  localparam int DT_W    = 16;
  localparam int POS_W   = 48;
  localparam int HEAD_W  = 40;
  localparam int ANGLE_W = 32;
  localparam int Q15_W   = 16;

  // CORDIC datapath: Q2.30 plus headroom, angle with sign headroom
  localparam int CW               = 34;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX_STEPS = 32;
  localparam int Q15_SHIFT        = 15;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] Q15_ROUND   = 34'sd16384;
  localparam logic signed [CW-1:0] Q15_MAX     = 34'sd32767;
  localparam logic signed [CW-1:0] Q15_MIN     = -34'sd32768;

  // Arctangent of 2^-i in 2^32-per-turn units, truncated
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_MAX_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // One beat moving down the CORDIC cell chain
  typedef struct packed {
    logic                 valid;
    logic                 flip;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_beat_t;

  // Rounded result leaving the CORDIC
  typedef struct packed {
    logic                    valid;
    logic signed [Q15_W-1:0] cos_q15;
    logic signed [Q15_W-1:0] sin_q15;
  } cordic_res_t;

  // Tick sequencer
  typedef enum logic [3:0] {
    S_IDLE,
    S_HMUL,
    S_HADD,
    S_ISSUE,
    S_WAIT_CS,
    S_WAIT_Q,
    S_PMUL,
    S_PSUM,
    S_PSCALE,
    S_ACC,
    S_OUT
  } seq_state_t;

endpackage

FILE: rtl/opi_if.sv
// Valid/ready channel interfaces for odometry ticks and pose results.
// Depends on opi_pkg for field widths.
interface opi_tick_if;
  import opi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] forward_speed;
  logic signed [SPEED_W-1:0] lateral_speed;
  logic signed [RATE_W-1:0]  yaw_rate;
  logic        [DT_W-1:0]    elapsed_us;

  modport source (output valid, forward_speed, lateral_speed, yaw_rate, elapsed_us,
                  input ready);
  modport sink   (input valid, forward_speed, lateral_speed, yaw_rate, elapsed_us,
                  output ready);
endinterface

interface opi_pose_if;
  import opi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [ANGLE_W-1:0]      heading;
  logic signed [Q15_W-1:0] quat_z;
  logic signed [Q15_W-1:0] quat_w;

  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w, output ready);
endinterface

FILE: rtl/odometry_pose_integrator.sv
// Top level of the planar dead-reckoning pose integrator.
// Depends on opi_pkg, opi_if and opi_cordic.
//
// Each tick beat is accepted, worked through the sequencer and written to
// the pose beat; one tick is in flight at a time, and the next tick can be
// taken in the cycle after the pose is loaded into the output register.
// The sequence is set by the CORDIC cell chain, which carries first the stored
// heading (for the velocity rotation) and then the half of the updated heading
// (for the quaternion), followed by the multiply, sum, scale and accumulate
// steps. A finished pose waits in an output register, and the next tick is
// taken while it waits. Positions saturate at 48 bits; the heading wraps at a
// full turn.
module odometry_pose_integrator #(
  parameter int CORDIC_STEPS = opi_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  opi_tick_if.sink   tick,
  opi_pose_if.source pose
);
  import opi_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  logic               issue_valid;
  logic [ANGLE_W-1:0] issue_angle;
  logic               out_load;
  cordic_res_t        cs;

  // Latched tick
  logic signed [SPEED_W-1:0] vx;
  logic signed [SPEED_W-1:0] vy;
  logic signed [RATE_W-1:0]  rate;
  logic        [DT_W-1:0]    dt;
  logic signed [DT_W:0]      dt_s;

  // Pose state
  logic signed [POS_W-1:0] position_x;
  logic signed [POS_W-1:0] position_y;
  logic [HEAD_W-1:0]       heading_angle;

  // Datapath
  logic signed [HEAD_W-1:0]      head_prod;
  logic signed [Q15_W-1:0]       cos_h;
  logic signed [Q15_W-1:0]       sin_h;
  logic signed [Q15_W-1:0]       qz;
  logic signed [Q15_W-1:0]       qw;
  logic signed [2*Q15_W-1:0]     m_xc;
  logic signed [2*Q15_W-1:0]     m_ys;
  logic signed [2*Q15_W-1:0]     m_xs;
  logic signed [2*Q15_W-1:0]     m_yc;
  logic signed [2*Q15_W:0]       sum_x;
  logic signed [2*Q15_W:0]       sum_y;
  logic signed [2*Q15_W+DT_W+1:0] scl_x;
  logic signed [2*Q15_W+DT_W+1:0] scl_y;
  logic signed [2*Q15_W+DT_W+1:0] dx;
  logic signed [2*Q15_W+DT_W+1:0] dy;
  logic signed [POS_W:0]         acc_x;
  logic signed [POS_W:0]         acc_y;

  // Output register
  logic                    pose_vld;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic [ANGLE_W-1:0]      out_head;
  logic signed [Q15_W-1:0] out_qz;
  logic signed [Q15_W-1:0] out_qw;

  opi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue_angle (issue_angle),
    .res         (cs)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (tick.valid) state_next = S_HMUL;
      S_HMUL:    state_next = S_HADD;
      S_HADD:    state_next = S_ISSUE;
      S_ISSUE:   state_next = S_WAIT_CS;
      S_WAIT_CS: if (cs.valid) state_next = S_WAIT_Q;
      S_WAIT_Q:  if (cs.valid) state_next = S_PMUL;
      S_PMUL:    state_next = S_PSUM;
      S_PSUM:    state_next = S_PSCALE;
      S_PSCALE:  state_next = S_ACC;
      S_ACC:     state_next = S_OUT;
      S_OUT:     if (!pose_vld || pose.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    tick.ready  = 1'b0;
    issue_valid = 1'b0;
    issue_angle = heading_angle[HEAD_W-1 -: ANGLE_W];
    out_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        tick.ready  = 1'b1;
        issue_valid = tick.valid;
      end
      S_ISSUE: begin
        issue_valid = 1'b1;
        issue_angle = {1'b0, heading_angle[HEAD_W-1 -: ANGLE_W-1]};
      end
      S_OUT: begin
        out_load = !pose_vld || pose.ready;
      end
      default: begin
        issue_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign dt_s  = signed'({1'b0, dt});
  assign dx    = (scl_x + (2*Q15_W+DT_W+2)'(Q15_ROUND)) >>> Q15_SHIFT;
  assign dy    = (scl_y + (2*Q15_W+DT_W+2)'(Q15_ROUND)) >>> Q15_SHIFT;
  assign acc_x = {position_x[POS_W-1], position_x} + dx[POS_W:0];
  assign acc_y = {position_y[POS_W-1], position_y} + dy[POS_W:0];

  // Capture the tick and run the arithmetic steps
  always_ff @(posedge clk) begin
    if (state == S_IDLE && tick.valid) begin
      vx   <= tick.forward_speed;
      vy   <= tick.lateral_speed;
      rate <= tick.yaw_rate;
      dt   <= tick.elapsed_us;
    end
    if (state == S_HMUL) begin
      head_prod <= HEAD_W'(rate) * HEAD_W'(dt_s);
    end
    if (state == S_WAIT_CS && cs.valid) begin
      cos_h <= cs.cos_q15;
      sin_h <= cs.sin_q15;
    end
    if (state == S_WAIT_Q && cs.valid) begin
      qw <= cs.cos_q15;
      qz <= cs.sin_q15;
    end
    if (state == S_PMUL) begin
      m_xc <= (2*Q15_W)'(vx) * (2*Q15_W)'(cos_h);
      m_ys <= (2*Q15_W)'(vy) * (2*Q15_W)'(sin_h);
      m_xs <= (2*Q15_W)'(vx) * (2*Q15_W)'(sin_h);
      m_yc <= (2*Q15_W)'(vy) * (2*Q15_W)'(cos_h);
    end
    if (state == S_PSUM) begin
      sum_x <= (2*Q15_W+1)'(m_xc) - (2*Q15_W+1)'(m_ys);
      sum_y <= (2*Q15_W+1)'(m_xs) + (2*Q15_W+1)'(m_yc);
    end
    if (state == S_PSCALE) begin
      scl_x <= (2*Q15_W+DT_W+2)'(sum_x) * (2*Q15_W+DT_W+2)'(dt_s);
      scl_y <= (2*Q15_W+DT_W+2)'(sum_y) * (2*Q15_W+DT_W+2)'(dt_s);
    end
  end

  // Pose state: heading wraps, positions saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_angle <= '0;
      position_x    <= '0;
      position_y    <= '0;
    end else begin
      if (state == S_HADD) begin
        heading_angle <= heading_angle + unsigned'(head_prod);
      end
      if (state == S_ACC) begin
        if (acc_x[POS_W] != acc_x[POS_W-1]) begin
          position_x <= acc_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
          position_x <= acc_x[POS_W-1:0];
        end
        if (acc_y[POS_W] != acc_y[POS_W-1]) begin
          position_y <= acc_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
          position_y <= acc_y[POS_W-1:0];
        end
      end
    end
  end

  // Output register: load a finished pose, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_vld <= 1'b0;
    end else if (out_load) begin
      pose_vld <= 1'b1;
    end else if (pose.ready) begin
      pose_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x    <= position_x;
      out_y    <= position_y;
      out_head <= heading_angle[HEAD_W-1 -: ANGLE_W];
      out_qz   <= qz;
      out_qw   <= qw;
    end
  end

  assign pose.valid   = pose_vld;
  assign pose.pos_x   = out_x;
  assign pose.pos_y   = out_y;
  assign pose.heading = out_head;
  assign pose.quat_z  = out_qz;
  assign pose.quat_w  = out_qw;

endmodule

FILE: rtl/opi_cell.sv
// One CORDIC rotation cell: fixed shift and fixed arctangent, registered.
// Depends on opi_pkg for the beat type.
module opi_cell #(
  parameter int              SHIFT = 0,
  parameter logic [31:0]     ATAN  = 32'h20000000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  opi_pkg::cordic_beat_t beat_in,
  output opi_pkg::cordic_beat_t beat_out
);
  import opi_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] atan_s;
  cordic_beat_t         beat_next;

  assign xs     = beat_in.x >>> SHIFT;
  assign ys     = beat_in.y >>> SHIFT;
  assign atan_s = signed'({{(CW-ANGLE_W){1'b0}}, ATAN});

  // Rotate toward zero residual angle
  always_comb begin
    beat_next = beat_in;
    if (!beat_in.z[CW-1]) begin
      beat_next.x = beat_in.x - ys;
      beat_next.y = beat_in.y + xs;
      beat_next.z = beat_in.z - atan_s;
    end else begin
      beat_next.x = beat_in.x + ys;
      beat_next.y = beat_in.y - xs;
      beat_next.z = beat_in.z + atan_s;
    end
  end

  // Hand the beat to the next cell
  always_ff @(posedge clk) begin
    beat_out.flip <= beat_next.flip;
    beat_out.x    <= beat_next.x;
    beat_out.y    <= beat_next.y;
    beat_out.z    <= beat_next.z;
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else begin
      beat_out.valid <= beat_next.valid;
    end
  end

endmodule

FILE: rtl/opi_cordic.sv
// Pipelined CORDIC: half-plane fold, a chain of opi_cell stages, Q1.15 rounding.
// Depends on opi_pkg and opi_cell. Registered at the input, in each cell and at the output, no stall.
module opi_cordic #(
  parameter int STEPS = opi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue_valid,
  input  logic [opi_pkg::ANGLE_W-1:0]   issue_angle,
  output opi_pkg::cordic_res_t          res
);
  import opi_pkg::*;

  cordic_beat_t          chain [STEPS+1];
  logic                  flip_c;
  logic [ANGLE_W-1:0]    folded;
  cordic_beat_t          last;
  logic signed [CW-1:0]  x_f;
  logic signed [CW-1:0]  y_f;
  logic signed [CW-1:0]  x_r;
  logic signed [CW-1:0]  y_r;

  // Fold the angle into the right half-plane
  assign flip_c = (issue_angle[ANGLE_W-1] != issue_angle[ANGLE_W-2]);
  assign folded = flip_c ? issue_angle + {1'b1, {(ANGLE_W-1){1'b0}}} : issue_angle;

  // Load the first cell
  always_ff @(posedge clk) begin
    chain[0].flip  <= flip_c;
    chain[0].x     <= CORDIC_GAIN;
    chain[0].y     <= '0;
    chain[0].z     <= signed'({{(CW-ANGLE_W){folded[ANGLE_W-1]}}, folded});
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid <= issue_valid;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    opi_cell #(
      .SHIFT (i),
      .ATAN  (ATAN_TURNS[i])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  // Undo the fold and round to Q1.15
  assign last = chain[STEPS];
  assign x_f  = last.flip ? -last.x : last.x;
  assign y_f  = last.flip ? -last.y : last.y;
  assign x_r  = (x_f + Q15_ROUND) >>> Q15_SHIFT;
  assign y_r  = (y_f + Q15_ROUND) >>> Q15_SHIFT;

  always_ff @(posedge clk) begin
    res.cos_q15 <= (x_r > Q15_MAX) ? Q15_MAX[Q15_W-1:0] :
                   (x_r < Q15_MIN) ? Q15_MIN[Q15_W-1:0] : x_r[Q15_W-1:0];
    res.sin_q15 <= (y_r > Q15_MAX) ? Q15_MAX[Q15_W-1:0] :
                   (y_r < Q15_MIN) ? Q15_MIN[Q15_W-1:0] : y_r[Q15_W-1:0];
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= last.valid;
    end
  end

endmodule

FILE: rtl/opi_checker.sv
// Port-level checks for odometry_pose_integrator, attached by bind.
// Depends on the top level's channel interfaces only.
module opi_checker (
  input logic        clk,
  input logic        rst,
  input logic        tick_valid,
  input logic        tick_ready,
  input logic        pose_valid,
  input logic        pose_ready,
  input logic [31:0] pose_heading
);

  // Reset leaves no result pending and the block open for a tick
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !pose_valid && tick_ready)
    else $error("pose pending or tick blocked after reset");

  // One tick in flight: acceptance closes the tick side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted while another is in flight");

  // A new pose appears only as a tick finishes its work
  a_pose_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(!tick_ready))
    else $error("pose appeared with no tick in progress");

  // A stalled pose holds
  a_pose_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && !pose_ready |=> pose_valid && $stable(pose_heading))
    else $error("stalled pose changed");

endmodule

bind odometry_pose_integrator opi_checker u_opi_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .pose_valid   (pose.valid),
  .pose_ready   (pose.ready),
  .pose_heading (pose.heading)
);
